// ===== rtl/crpb_pkg.sv =====
package crpb_pkg;

   localparam int RAM_WORDS = 4096;
   localparam int ADDR_W    = $clog2(RAM_WORDS);

   // Request kinds carried in the req_type field.
   localparam logic [1:0] REQ_RD_BYTE = 2'd0;
   localparam logic [1:0] REQ_RD_WORD = 2'd1;
   localparam logic [1:0] REQ_WR_BYTE = 2'd2;
   localparam logic [1:0] REQ_WR_WORD = 2'd3;

   // Word and word-pair addresses of the palette and bank helper bytes.
   localparam logic [ADDR_W-1:0]   UNPACK_SRC_WORD = 12'hFF0;
   localparam logic [ADDR_W-1:0]   UNPACK_HI_WORD  = 12'hFF1;
   localparam logic [ADDR_W-1:0]   UNPACK_LO_WORD  = 12'hFF2;
   localparam logic [ADDR_W-2:0]   PACK_SRC_PAIR   = 11'h7FA;
   localparam logic [ADDR_W-1:0]   PACK_DST_WORD   = 12'hFF6;
   localparam logic [ADDR_W-2:0]   BANK_PAIR       = 11'h7FC;
   localparam logic [ADDR_W-1:0]   BANK_LO_WORD    = 12'hFF8;
   localparam logic [ADDR_W-1:0]   BANK_HI_WORD    = 12'hFF9;

   localparam logic [7:0]  BANK_F1_VALUE = 8'hA0;
   localparam logic [7:0]  BANK_F0_MASK  = 8'hFE;
   localparam logic [7:0]  BANK_F2_MASK  = 8'h7F;
   localparam logic [24:0] ROM_BASE      = 25'h100000;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [12:0] byte_offset;
      logic [15:0] write_data;
   } req_item_type;

   typedef struct packed {
      logic [15:0] read_data;
      logic        bank_update;
      logic [24:0] rom_offset;
   } rsp_item_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [15:0]       wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } mem_req_type;

   typedef enum logic [1:0] {
      FX_NONE,
      FX_UNPACK,
      FX_PACK,
      FX_BANK
   } effect_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MAIN,
      ST_AUX,
      ST_SECOND,
      ST_HOLD
   } state_type;

endpackage

// ===== rtl/crpb_ram.sv =====
module crpb_ram
   import crpb_pkg::*;
(
   input  logic        clock,
   input  mem_req_type mem_req,
   output logic [15:0] rd_data
);

   logic [15:0] ram_ff [RAM_WORDS];
   logic [15:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         ram_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= ram_ff[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/crpb_ctrl.sv =====
module crpb_ctrl
   import crpb_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_data,
   output mem_req_type  mem_req,
   input  logic [15:0]  rd_data
);

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] clr_ff;
   logic [1:0]        kind_ff;
   logic [12:0]       off_ff;
   logic [15:0]       data_ff;
   effect_type        fx_ff, fx_in;
   logic [15:0]       word_ff, word_in;
   logic [15:0]       second_ff, second_in;
   logic [24:0]       rom_ff, rom_in;
   rsp_item_type      res_ff, res_next;
   rsp_item_type      rsp_ff;
   logic              rsp_valid_ff;
   logic              fin;
   logic              out_free;
   logic              accept;
   logic              rsp_load;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_load  = out_free && (fin || (state_ff == ST_HOLD));
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Only writes can trigger a helper; bit 0 plays no part in any window test.
   always_comb begin
      fx_in = FX_NONE;
      if (req_data.req_type == REQ_WR_BYTE || req_data.req_type == REQ_WR_WORD) begin
         if (req_data.byte_offset[12:1] == UNPACK_SRC_WORD) begin
            fx_in = FX_UNPACK;
         end else if (req_data.byte_offset[12:2] == PACK_SRC_PAIR) begin
            fx_in = FX_PACK;
         end else if (req_data.byte_offset[12:2] == BANK_PAIR) begin
            fx_in = FX_BANK;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_MAIN;
            end
         end
         ST_MAIN: begin
            if (fin) begin
               state_in = out_free ? ST_IDLE : ST_HOLD;
            end else begin
               state_in = ST_AUX;
            end
         end
         ST_AUX: begin
            if (fin) begin
               state_in = out_free ? ST_IDLE : ST_HOLD;
            end else begin
               state_in = ST_SECOND;
            end
         end
         ST_SECOND: begin
            state_in = out_free ? ST_IDLE : ST_HOLD;
         end
         ST_HOLD: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      logic [15:0] lo_w;
      logic [15:0] hi_w;
      logic [7:0]  b1;
      logic [7:0]  b2;
      logic [7:0]  b3;
      logic [7:0]  b4;
      logic [7:0]  pack_lo;
      logic [7:0]  pack_hi;

      mem_req   = '0;
      fin       = 1'b0;
      res_next  = '0;
      word_in   = word_ff;
      second_in = second_ff;
      rom_in    = rom_ff;

      // In the helper steps one word of the pair is the one just written and
      // the other comes from the partner read.
      lo_w = off_ff[1] ? rd_data : word_ff;
      hi_w = off_ff[1] ? word_ff : rd_data;
      b1   = lo_w[15:8];
      b2   = lo_w[7:0];
      b3   = hi_w[15:8];
      b4   = hi_w[7:0];
      pack_lo = {b1[4:1], 4'b0000} | {1'b0, b2[7:1]};
      pack_hi = {1'b0, b4[7:1]} | {b3[0], b4[0], b1[0], b2[0], 4'b0000};

      case (state_ff)
         ST_CLEAR: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = clr_ff;
            mem_req.wr_data = '0;
         end
         ST_IDLE: begin
            mem_req.rd_en   = req_valid;
            mem_req.rd_addr = req_data.byte_offset[12:1];
         end
         ST_MAIN: begin
            if (kind_ff == REQ_RD_BYTE) begin
               fin = 1'b1;
               res_next.read_data = {8'h00, off_ff[0] ? rd_data[7:0] : rd_data[15:8]};
            end else if (kind_ff == REQ_RD_WORD) begin
               fin = 1'b1;
               res_next.read_data = rd_data;
            end else begin
               if (kind_ff == REQ_WR_WORD) begin
                  word_in = data_ff;
               end else if (off_ff[0]) begin
                  word_in = {rd_data[15:8], data_ff[7:0]};
               end else begin
                  word_in = {data_ff[7:0], rd_data[7:0]};
               end
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = off_ff[12:1];
               mem_req.wr_data = word_in;
               mem_req.rd_en   = (fx_ff == FX_PACK) || (fx_ff == FX_BANK);
               mem_req.rd_addr = {off_ff[12:2], ~off_ff[1]};
               fin = (fx_ff == FX_NONE);
            end
         end
         ST_AUX: begin
            mem_req.wr_en = 1'b1;
            case (fx_ff)
               FX_UNPACK: begin
                  mem_req.wr_addr = UNPACK_HI_WORD;
                  mem_req.wr_data = {3'b000, word_ff[7:4], word_ff[13],
                                     3'b000, word_ff[3:0], word_ff[12]};
                  second_in = {7'b0000000, word_ff[15],
                               3'b000, word_ff[11:8], word_ff[14]};
               end
               FX_PACK: begin
                  mem_req.wr_addr = PACK_DST_WORD;
                  mem_req.wr_data = {pack_hi, pack_lo};
                  fin = 1'b1;
               end
               FX_BANK: begin
                  mem_req.wr_addr = BANK_LO_WORD;
                  mem_req.wr_data = {b1 & BANK_F0_MASK, BANK_F1_VALUE};
                  second_in = {b3 & BANK_F2_MASK, b4};
                  rom_in    = {1'b0, b3, b4, b1} + ROM_BASE;
               end
               default: begin
                  mem_req.wr_en = 1'b0;
                  fin = 1'b1;
               end
            endcase
         end
         ST_SECOND: begin
            fin = 1'b1;
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = (fx_ff == FX_BANK) ? BANK_HI_WORD : UNPACK_LO_WORD;
            mem_req.wr_data = second_ff;
            if (fx_ff == FX_BANK) begin
               res_next.bank_update = 1'b1;
               res_next.rom_offset  = rom_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff <= req_data.req_type;
         off_ff  <= req_data.byte_offset;
         data_ff <= req_data.write_data;
         fx_ff   <= fx_in;
      end
      word_ff   <= word_in;
      second_ff <= second_in;
      rom_ff    <= rom_in;
      if (fin) begin
         res_ff <= res_next;
      end
      if (rsp_load) begin
         rsp_ff <= (state_ff == ST_HOLD) ? res_ff : res_next;
      end
   end

endmodule

// ===== rtl/cart_ram_palette_bank_device_core.sv =====
// A read or plain write passes through the IDLE and MAIN states, a palette pack write also
// through AUX, and a palette unpack or bank write through AUX and SECOND, as set by the single
// RAM read port and one RAM write per cycle. One item is in work at a time, so a new item is
// accepted only once the last is through; a finished result that finds the output register
// busy waits in a hold register. After reset a clearing pass writes zero to all 4096 RAM
// words, one a cycle, and no item is accepted until it ends.
module cart_ram_palette_bank_device_core
   import crpb_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_data
);

   mem_req_type mem_req;
   logic [15:0] rd_data;

   crpb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .mem_req   (mem_req),
      .rd_data   (rd_data)
   );

   crpb_ram u_ram (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   a_clear_after_reset: assert property (@(posedge clock)
      !reset && $past(reset) |-> req_stall)
      else $error("item accepted straight after reset");

   a_bank_offset_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.bank_update |-> rsp_data.rom_offset >= ROM_BASE)
      else $error("bank switch reported an offset below the ROM base");

   a_no_bank_no_offset: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.bank_update |-> rsp_data.rom_offset == '0)
      else $error("ROM offset reported without a bank switch");

   a_bank_no_read_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.bank_update |-> rsp_data.read_data == '0)
      else $error("bank switch item carries read data");

endmodule

// ===== bench/cart_ram_palette_bank_device_core_test.sv =====
`timescale 1ns / 1ps

module cart_ram_palette_bank_device_core_test;
   import crpb_pkg::*;

   localparam logic [12:0] PAL_UNPACK_BASE = 13'h1FE0;
   localparam logic [12:0] PAL_PACK_BASE   = 13'h1FE8;
   localparam logic [12:0] BANK_BASE       = 13'h1FF0;
   localparam logic [12:0] PAL_WORK_BASE   = 13'h1FE2;
   localparam logic [12:0] PAL_PACKED      = 13'h1FEC;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_item_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_data;

   // Image of the cartridge RAM as the bus should see it.
   logic [15:0]  ram_image [RAM_WORDS];
   rsp_item_type bus_reply_q [$];
   rsp_item_type oldest_reply;
   int           mismatches = 0;
   bit           sender_idle_on = 1'b1;
   bit           receiver_idle_on = 1'b1;
   int           long_hold_cycles = 0;

   cart_ram_palette_bank_device_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [7:0] image_byte(input logic [12:0] off);
      logic [15:0] w;
      w = ram_image[off[12:1]];
      return off[0] ? w[7:0] : w[15:8];
   endfunction

   function automatic void put_image_byte(input logic [12:0] off, input logic [7:0] v);
      if (off[0])
         ram_image[off[12:1]][7:0] = v;
      else
         ram_image[off[12:1]][15:8] = v;
   endfunction

   // Works out the reply to one bus access and applies its side effects.
   function automatic rsp_item_type access_ram_image(input req_item_type item);
      logic [12:0]  off;
      logic [7:0]   b1, b2, b3, b4;
      logic [23:0]  bank;
      rsp_item_type reply;
      reply = '0;
      off = item.byte_offset;
      if (item.req_type == REQ_RD_WORD || item.req_type == REQ_WR_WORD)
         off[0] = 1'b0;
      case (item.req_type)
         REQ_RD_BYTE: reply.read_data = {8'h00, image_byte(off)};
         REQ_RD_WORD: reply.read_data = ram_image[off[12:1]];
         default: begin
            if (item.req_type == REQ_WR_BYTE)
               put_image_byte(off, item.write_data[7:0]);
            else
               ram_image[off[12:1]] = item.write_data;
            // Side effects read the RAM after the written data has landed.
            if (off >= PAL_UNPACK_BASE && off <= PAL_UNPACK_BASE + 13'd1) begin
               b1 = image_byte(PAL_UNPACK_BASE);
               b2 = image_byte(PAL_UNPACK_BASE + 13'd1);
               put_image_byte(PAL_UNPACK_BASE + 13'd3, {3'b000, b2[3:0], b1[4]});
               put_image_byte(PAL_UNPACK_BASE + 13'd2, {3'b000, b2[7:4], b1[5]});
               put_image_byte(PAL_UNPACK_BASE + 13'd5, {3'b000, b1[3:0], b1[6]});
               put_image_byte(PAL_UNPACK_BASE + 13'd4, {7'b0000000, b1[7]});
            end else if (off >= PAL_PACK_BASE && off <= PAL_PACK_BASE + 13'd3) begin
               b1 = image_byte(PAL_PACK_BASE);
               b2 = image_byte(PAL_PACK_BASE + 13'd1);
               b3 = image_byte(PAL_PACK_BASE + 13'd2);
               b4 = image_byte(PAL_PACK_BASE + 13'd3);
               put_image_byte(PAL_PACKED + 13'd1, {1'b0, b2[7:1]} | {b1[4:1], 4'b0000});
               put_image_byte(PAL_PACKED,
                              {1'b0, b4[7:1]} | {b3[0], b4[0], b1[0], b2[0], 4'b0000});
            end else if (off >= BANK_BASE && off <= BANK_BASE + 13'd3) begin
               bank = {image_byte(BANK_BASE + 13'd2), image_byte(BANK_BASE + 13'd3),
                       image_byte(BANK_BASE)};
               put_image_byte(BANK_BASE + 13'd1, BANK_F1_VALUE);
               put_image_byte(BANK_BASE, image_byte(BANK_BASE) & BANK_F0_MASK);
               put_image_byte(BANK_BASE + 13'd2, image_byte(BANK_BASE + 13'd2) & BANK_F2_MASK);
               reply.bank_update = 1'b1;
               reply.rom_offset  = {1'b0, bank} + ROM_BASE;
            end
         end
      endcase
      return reply;
   endfunction

   task automatic send_item(input logic [1:0] kind, input logic [12:0] off,
                            input logic [15:0] data);
      req_item_type item;
      item.req_type    = kind;
      item.byte_offset = off;
      item.write_data  = data;
      if (sender_idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bus_reply_q.push_back(access_ram_image(item));
   endtask

   task automatic drain_replies();
      req_valid <= 1'b0;
      while (bus_reply_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   function automatic logic [12:0] pick_offset();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return PAL_UNPACK_BASE + 13'($urandom_range(0, 31));
         4, 5, 6:    return 13'($urandom_range(0, 63));
         default:    return 13'($urandom_range(0, 8191));
      endcase
   endfunction

   task automatic test_directed();
      send_item(REQ_RD_BYTE, 13'h0000, 16'h0000);
      send_item(REQ_RD_BYTE, 13'h1FFF, 16'hFFFF);
      send_item(REQ_WR_WORD, 13'h0000, 16'hFFFF);
      send_item(REQ_RD_BYTE, 13'h0000, 16'h0000);
      send_item(REQ_RD_BYTE, 13'h0001, 16'h0000);
      send_item(REQ_RD_WORD, 13'h0001, 16'h0000);
      // The high byte of a byte write's data must be ignored.
      send_item(REQ_WR_BYTE, 13'h1FFF, 16'hFF5A);
      send_item(REQ_RD_WORD, 13'h1FFE, 16'h0000);
      send_item(REQ_WR_WORD, PAL_UNPACK_BASE + 13'd1, 16'hB7C3);
      send_item(REQ_RD_WORD, PAL_WORK_BASE, 16'h0000);
      send_item(REQ_RD_WORD, PAL_WORK_BASE + 13'd2, 16'h0000);
      send_item(REQ_WR_BYTE, PAL_UNPACK_BASE + 13'd1, 16'h005E);
      send_item(REQ_WR_BYTE, PAL_PACK_BASE, 16'h00FF);
      send_item(REQ_WR_BYTE, PAL_PACK_BASE + 13'd1, 16'h0055);
      send_item(REQ_WR_BYTE, PAL_PACK_BASE + 13'd2, 16'h0001);
      send_item(REQ_WR_WORD, PAL_PACK_BASE + 13'd3, 16'hAAAB);
      send_item(REQ_RD_WORD, PAL_PACKED, 16'h0000);
      send_item(REQ_WR_WORD, BANK_BASE, 16'hFFFF);
      send_item(REQ_RD_WORD, BANK_BASE, 16'h0000);
      send_item(REQ_WR_BYTE, BANK_BASE + 13'd3, 16'h0000);
      send_item(REQ_WR_BYTE, BANK_BASE + 13'd2, 16'hFF80);
      send_item(REQ_RD_WORD, BANK_BASE + 13'd2, 16'h0000);
      // Neighbours of the helper ranges trigger nothing.
      send_item(REQ_WR_BYTE, PAL_UNPACK_BASE - 13'd1, 16'h00FF);
      send_item(REQ_WR_WORD, BANK_BASE + 13'd4, 16'h1234);
   endtask

   task automatic test_random_mix();
      for (int i = 0; i < 1000; i++)
         send_item(2'($urandom_range(0, 3)), pick_offset(), 16'($urandom));
   endtask

   task automatic test_palette_sequences();
      for (int i = 0; i < 110; i++) begin
         case ($urandom_range(0, 3))
            0: begin
               if ($urandom_range(0, 1))
                  send_item(REQ_WR_WORD, PAL_UNPACK_BASE, 16'($urandom));
               else
                  send_item(REQ_WR_BYTE, PAL_UNPACK_BASE + 13'($urandom_range(0, 1)),
                            16'($urandom));
               send_item(REQ_RD_WORD, PAL_WORK_BASE, 16'($urandom));
               send_item(REQ_RD_WORD, PAL_WORK_BASE + 13'd2, 16'($urandom));
            end
            1: begin
               for (int k = 0; k < 4; k++)
                  send_item(REQ_WR_BYTE, PAL_PACK_BASE + 13'(k), 16'($urandom));
               send_item(REQ_RD_WORD, PAL_PACKED, 16'($urandom));
            end
            2: begin
               send_item(REQ_WR_BYTE, BANK_BASE + 13'($urandom_range(0, 3)), 16'($urandom));
               send_item(REQ_WR_WORD, BANK_BASE + 13'd2, 16'($urandom));
               send_item(REQ_RD_WORD, BANK_BASE, 16'($urandom));
               send_item(REQ_RD_BYTE, BANK_BASE + 13'($urandom_range(0, 3)), 16'($urandom));
            end
            default: begin
               // A broken sequence: a lone write into the helper area, then noise.
               send_item(REQ_WR_BYTE, PAL_UNPACK_BASE + 13'($urandom_range(0, 31)),
                         16'($urandom));
               send_item(2'($urandom_range(0, 3)), 13'($urandom), 16'($urandom));
            end
         endcase
      end
   endtask

   task automatic test_backpressure();
      sender_idle_on   = 1'b0;
      long_hold_cycles = 80;
      for (int i = 0; i < 40; i++)
         send_item(2'($urandom_range(0, 3)), pick_offset(), 16'($urandom));
      sender_idle_on = 1'b1;
   endtask

   task automatic test_streaming();
      sender_idle_on   = 1'b0;
      receiver_idle_on = 1'b0;
      for (int i = 0; i < 450; i++)
         send_item(2'($urandom_range(0, 3)), pick_offset(), 16'($urandom));
   endtask

   initial begin : receiver
      int stretch;
      forever begin
         @(posedge clock);
         if (long_hold_cycles != 0) begin
            stretch = long_hold_cycles;
            long_hold_cycles = 0;
            rsp_stall <= 1'b1;
            repeat (stretch) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (receiver_idle_on && $urandom_range(0, 4) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic check_field(input string label, input logic [24:0] want,
                              input logic [24:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %h, actual %h", $time, label, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (bus_reply_q.size() == 0) begin
            $display("%0t: no item expected, actual %h", $time, rsp_data);
            mismatches++;
         end else begin
            oldest_reply = bus_reply_q.pop_front();
            check_field("read_data", 25'(oldest_reply.read_data), 25'(rsp_data.read_data));
            check_field("bank_update", 25'(oldest_reply.bank_update),
                        25'(rsp_data.bank_update));
            check_field("rom_offset", oldest_reply.rom_offset, rsp_data.rom_offset);
         end
      end
   end

   initial begin
      #8_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      foreach (ram_image[i]) ram_image[i] = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      drain_replies();
      test_random_mix();
      drain_replies();
      test_palette_sequences();
      drain_replies();
      test_backpressure();
      drain_replies();
      test_streaming();
      drain_replies();
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/crpb_pkg.sv
rtl/crpb_ram.sv
rtl/crpb_ctrl.sv
rtl/cart_ram_palette_bank_device_core.sv
bench/cart_ram_palette_bank_device_core_test.sv
